// ===== rtl/bor_pkg.sv =====
`default_nettype none

package bor_pkg;

    // Default geometry of the block.
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Command codes carried in the input item's tuser.
    localparam logic CMD_IOU = 1'b0;  // overlap over union area
    localparam logic CMD_IOA = 1'b1;  // overlap over area of the first box

endpackage

`default_nettype wire

// ===== rtl/bor_front.sv =====
`default_nettype none

module bor_front
    import bor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic                      in_cmd,
    input  wire logic [COORD_BITS-1:0]     a_x,
    input  wire logic [COORD_BITS-1:0]     a_y,
    input  wire logic [COORD_BITS-1:0]     a_w,
    input  wire logic [COORD_BITS-1:0]     a_h,
    input  wire logic [COORD_BITS-1:0]     b_x,
    input  wire logic [COORD_BITS-1:0]     b_y,
    input  wire logic [COORD_BITS-1:0]     b_w,
    input  wire logic [COORD_BITS-1:0]     b_h,
    output logic                           out_valid,
    output logic                           out_zero,
    output logic [2*COORD_BITS-1:0]        out_overlap,
    output logic [2*COORD_BITS:0]          out_denom
);

    localparam int C = COORD_BITS;
    localparam int A = 2 * COORD_BITS;
    localparam int D = 2 * COORD_BITS + 1;

    // Stage 1: far edges, areas and the span on each axis.
    logic [C:0]   ax1, ay1, bx1, by1;
    logic [C:0]   near_x, near_y, far_x, far_y;
    logic [C:0]   span_x_full, span_y_full;
    logic         apart;

    logic         s1_valid_reg;
    logic         s1_cmd_reg;
    logic [A-1:0] s1_area_a_reg, s1_area_b_reg;
    logic [C-1:0] s1_span_x_reg, s1_span_y_reg;

    // Stage 2: overlap product.
    logic         s2_valid_reg;
    logic         s2_cmd_reg;
    logic [A-1:0] s2_area_a_reg, s2_area_b_reg;
    logic [A-1:0] s2_overlap_reg;

    // Stage 3: denominator.
    logic [D-1:0] union_area;
    logic [D-1:0] denom_next;

    always_comb begin
        ax1 = {1'b0, a_x} + {1'b0, a_w};
        ay1 = {1'b0, a_y} + {1'b0, a_h};
        bx1 = {1'b0, b_x} + {1'b0, b_w};
        by1 = {1'b0, b_y} + {1'b0, b_h};

        apart = ({1'b0, b_x} > ax1) || ({1'b0, a_x} > bx1) ||
                ({1'b0, b_y} > ay1) || ({1'b0, a_y} > by1);

        near_x = (a_x > b_x) ? {1'b0, a_x} : {1'b0, b_x};
        near_y = (a_y > b_y) ? {1'b0, a_y} : {1'b0, b_y};
        far_x  = (ax1 < bx1) ? ax1 : bx1;
        far_y  = (ay1 < by1) ? ay1 : by1;

        // A span never exceeds the narrower box, so it fits the coordinate width.
        span_x_full = far_x - near_x;
        span_y_full = far_y - near_y;

        union_area = {1'b0, s2_area_a_reg} + {1'b0, s2_area_b_reg}
                     - {1'b0, s2_overlap_reg};

        unique case (s2_cmd_reg)
            CMD_IOU: denom_next = union_area;
            CMD_IOA: denom_next = {1'b0, s2_area_a_reg};
            default: denom_next = union_area;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            out_valid    <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_cmd_reg    <= in_cmd;
            s1_area_a_reg <= a_w * a_h;
            s1_area_b_reg <= b_w * b_h;
            s1_span_x_reg <= apart ? '0 : span_x_full[C-1:0];
            s1_span_y_reg <= apart ? '0 : span_y_full[C-1:0];

            s2_cmd_reg     <= s1_cmd_reg;
            s2_area_a_reg  <= s1_area_a_reg;
            s2_area_b_reg  <= s1_area_b_reg;
            s2_overlap_reg <= s1_span_x_reg * s1_span_y_reg;

            out_overlap <= s2_overlap_reg;
            out_denom   <= denom_next;
            out_zero    <= (denom_next == '0);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bor_div_cell.sv =====
`default_nettype none

module bor_div_cell
    import bor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic                      in_zero,
    input  wire logic [2*COORD_BITS+1:0]   in_rem,
    input  wire logic [2*COORD_BITS:0]     in_denom,
    input  wire logic [2*COORD_BITS-1:0]   in_overlap,
    input  wire logic [FRAC_BITS:0]        in_q,
    output logic                           out_valid,
    output logic                           out_zero,
    output logic [2*COORD_BITS:0]          out_rem,
    output logic [2*COORD_BITS:0]          out_denom,
    output logic [2*COORD_BITS-1:0]        out_overlap,
    output logic [FRAC_BITS:0]             out_q
);

    localparam int D  = 2 * COORD_BITS + 1;
    localparam int RB = FRAC_BITS + 1;

    logic [D:0] diff;
    logic       ge;

    // One restoring step: subtract the divisor when it fits and shift in the bit.
    always_comb begin
        diff = in_rem - {1'b0, in_denom};
        ge   = (in_rem >= {1'b0, in_denom});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (adv) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_zero    <= in_zero;
            out_denom   <= in_denom;
            out_overlap <= in_overlap;
            out_rem     <= ge ? diff[D-1:0] : in_rem[D-1:0];
            out_q       <= {in_q[RB-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/box_overlap_ratio_top.sv =====
// Channel  Dir  tdata fields (low bit up)                      tuser
// s_       in   a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h           cmd
// m_       out  ratio, overlap_area, denominator                 zero_denominator
//
// One item is accepted per cycle while m_tready does not stall the output; each result
// passes the front stages for edges and areas, overlap, and denominator,
// then one divider cell per quotient bit, FRAC_BITS + 1 cells in all.
// The whole pipeline advances whenever the output register is empty or taken,
// so a stall on m_tready holds every stage and drops s_tready in the same cycle.
// Reset clears only the valid bits of the stages.

`default_nettype none

module box_overlap_ratio_top
    import bor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_W  = ((8 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((FRAC_BITS + 1 + 4 * COORD_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h
    input  wire logic [IN_W-1:0]  s_tdata,
    // cmd
    input  wire logic             s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // ratio, overlap_area, denominator
    output logic [OUT_W-1:0]      m_tdata,
    // zero_denominator
    output logic                  m_tuser
);

    localparam int C  = COORD_BITS;
    localparam int A  = 2 * COORD_BITS;
    localparam int D  = 2 * COORD_BITS + 1;
    localparam int RB = FRAC_BITS + 1;

    logic adv;

    logic         f_valid, f_zero;
    logic [A-1:0] f_overlap;
    logic [D-1:0] f_denom;

    logic         c_valid   [RB+1];
    logic         c_zero    [RB+1];
    logic [D-1:0] c_rem     [RB+1];
    logic [D-1:0] c_denom   [RB+1];
    logic [A-1:0] c_overlap [RB+1];
    logic [RB-1:0] c_q      [RB+1];

    logic [RB-1:0] ratio;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    bor_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_cmd     (s_tuser),
        .a_x        (s_tdata[0*C +: C]),
        .a_y        (s_tdata[1*C +: C]),
        .a_w        (s_tdata[2*C +: C]),
        .a_h        (s_tdata[3*C +: C]),
        .b_x        (s_tdata[4*C +: C]),
        .b_y        (s_tdata[5*C +: C]),
        .b_w        (s_tdata[6*C +: C]),
        .b_h        (s_tdata[7*C +: C]),
        .out_valid  (f_valid),
        .out_zero   (f_zero),
        .out_overlap(f_overlap),
        .out_denom  (f_denom)
    );

    // The overlap never exceeds the denominator, so the first cell starts from the
    // overlap itself and the quotient fits FRAC_BITS + 1 bits.
    assign c_valid[0]   = f_valid;
    assign c_zero[0]    = f_zero;
    assign c_rem[0]     = {1'b0, f_overlap};
    assign c_denom[0]   = f_denom;
    assign c_overlap[0] = f_overlap;
    assign c_q[0]       = '0;

    for (genvar k = 0; k < RB; k++) begin : g_cell
        logic [D:0] rem_in;

        if (k == 0) begin : g_first
            assign rem_in = {1'b0, c_rem[k]};
        end else begin : g_next
            assign rem_in = {c_rem[k], 1'b0};
        end

        bor_div_cell #(
            .COORD_BITS(COORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .in_valid   (c_valid[k]),
            .in_zero    (c_zero[k]),
            .in_rem     (rem_in),
            .in_denom   (c_denom[k]),
            .in_overlap (c_overlap[k]),
            .in_q       (c_q[k]),
            .out_valid  (c_valid[k+1]),
            .out_zero   (c_zero[k+1]),
            .out_rem    (c_rem[k+1]),
            .out_denom  (c_denom[k+1]),
            .out_overlap(c_overlap[k+1]),
            .out_q      (c_q[k+1])
        );
    end

    // A zero divisor lets every step succeed; the flag forces the ratio back to zero.
    assign ratio    = c_zero[RB] ? '0 : c_q[RB];
    assign m_tvalid = c_valid[RB];
    assign m_tuser  = c_zero[RB];
    assign m_tdata  = OUT_W'({c_denom[RB], c_overlap[RB], ratio});

`ifndef SYNTHESIS
    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (c_denom[RB] == '0) && (c_overlap[RB] == '0))
        else $error("zero flag with nonzero denominator or overlap");

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (c_q[RB] <= (RB)'(1) << FRAC_BITS) || m_tuser)
        else $error("ratio above one");

    a_overlap_le_denom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, c_overlap[RB]} <= c_denom[RB]))
        else $error("overlap larger than denominator");

    a_full_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && ({1'b0, c_overlap[RB]} == c_denom[RB])
        |-> (ratio == (RB)'(1) << FRAC_BITS))
        else $error("equal overlap and denominator must give ratio one");
`endif

endmodule

`default_nettype wire

// ===== verif/box_overlap_ratio_top_tb.sv =====
module box_overlap_ratio_top_tb
    import bor_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB      = COORD_BITS_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int IN_W    = ((8 * CB + 7) / 8) * 8;
    localparam int OUT_W   = ((FB + 1 + 4 * CB + 1 + 7) / 8) * 8;
    localparam int RATIO_W = FB + 1;
    localparam int OVL_W   = 2 * CB;
    localparam int DEN_W   = 2 * CB + 1;
    localparam int COORD_MAX = (1 << CB) - 1;

    localparam int N_RANDOM   = 1030;
    localparam int PAUSE_AT   = 600;
    localparam int LONG_HOLD  = 300;
    localparam int HOLD_AT    = 150;
    localparam int TAIL_ITEMS = 100;
    localparam int DRAIN_WAIT = 40;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic          cmd;
        logic [CB-1:0] a_x, a_y, a_w, a_h;
        logic [CB-1:0] b_x, b_y, b_w, b_h;
    } box_pair_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [OVL_W-1:0]   overlap_area;
        logic [DEN_W-1:0]   denominator;
        logic               zero_denominator;
    } overlap_res_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;

    box_pair_t    pending_pairs[$];
    overlap_res_t expected_ratios[$];
    box_pair_t    cur_pair;
    overlap_res_t got;
    overlap_res_t want;

    int n_items = 0;
    int n_offered = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_fail = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_cnt = 0;
    bit long_hold_done = 1'b0;
    int cycle_cnt = 0;

    box_overlap_ratio_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h
        .s_tuser  (s_tuser),   // cmd
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // ratio, overlap_area, denominator
        .m_tuser  (m_tuser)    // zero_denominator
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic overlap_res_t predict_overlap(box_pair_t p);
        logic [63:0] ax1, ay1, bx1, by1;
        logic [63:0] area_a, area_b, span_x, span_y, ovl, den;
        logic        apart;
        overlap_res_t r;
        ax1 = 64'(p.a_x) + 64'(p.a_w);
        ay1 = 64'(p.a_y) + 64'(p.a_h);
        bx1 = 64'(p.b_x) + 64'(p.b_w);
        by1 = 64'(p.b_y) + 64'(p.b_h);
        area_a = 64'(p.a_w) * 64'(p.a_h);
        area_b = 64'(p.b_w) * 64'(p.b_h);
        // Edges that only meet still count as overlapping, with a zero span.
        apart = (64'(p.b_x) > ax1) || (64'(p.a_x) > bx1) ||
                (64'(p.b_y) > ay1) || (64'(p.a_y) > by1);
        ovl = 64'd0;
        if (!apart) begin
            span_x = ((ax1 < bx1) ? ax1 : bx1) - ((p.a_x > p.b_x) ? 64'(p.a_x) : 64'(p.b_x));
            span_y = ((ay1 < by1) ? ay1 : by1) - ((p.a_y > p.b_y) ? 64'(p.a_y) : 64'(p.b_y));
            ovl = span_x * span_y;
        end
        den = (p.cmd == CMD_IOU) ? area_a + area_b - ovl : area_a;
        r.zero_denominator = (den == 64'd0);
        r.ratio            = r.zero_denominator ? '0 : RATIO_W'((ovl << FB) / den);
        r.overlap_area     = OVL_W'(ovl);
        r.denominator      = DEN_W'(den);
        return r;
    endfunction

    function automatic box_pair_t make_pair(logic cmd, int ax, int ay, int aw, int ah,
                                            int bx, int by, int bw, int bh);
        box_pair_t p;
        p.cmd = cmd;
        p.a_x = CB'(ax); p.a_y = CB'(ay); p.a_w = CB'(aw); p.a_h = CB'(ah);
        p.b_x = CB'(bx); p.b_y = CB'(by); p.b_w = CB'(bw); p.b_h = CB'(bh);
        return p;
    endfunction

    function automatic int sat_coord(int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Most pairs overlap or nearly touch, since far-apart boxes all give zero.
    function automatic box_pair_t rand_pair();
        box_pair_t p;
        int mode, ax, ay, aw, ah;
        mode = $urandom_range(0, 9);
        p = box_pair_t'({$urandom, $urandom, $urandom, $urandom});
        if (mode >= 2) begin
            ax = $urandom_range(0, COORD_MAX);
            ay = $urandom_range(0, COORD_MAX);
            aw = (mode == 2) ? $urandom_range(0, 8) : $urandom_range(0, 1023);
            ah = (mode == 2) ? $urandom_range(0, 8) : $urandom_range(0, 1023);
            if ($urandom_range(0, 15) == 0) begin
                aw = $urandom_range(0, COORD_MAX);
                ah = $urandom_range(0, COORD_MAX);
            end
            p.a_x = CB'(ax); p.a_y = CB'(ay); p.a_w = CB'(aw); p.a_h = CB'(ah);
            p.b_w = (mode == 2) ? CB'($urandom_range(0, 8)) : CB'($urandom_range(0, 1023));
            p.b_h = (mode == 2) ? CB'($urandom_range(0, 8)) : CB'($urandom_range(0, 1023));
            if (mode == 2) begin
                p.b_x = CB'(sat_coord(ax + $urandom_range(0, 20) - 10));
                p.b_y = CB'(sat_coord(ay + $urandom_range(0, 20) - 10));
            end else if (mode == 3) begin
                // Edge to edge on one axis, overlapping on the other.
                p.b_x = CB'(sat_coord(ax + aw));
                p.b_y = CB'(sat_coord(ay + $urandom_range(0, ah)));
                if ($urandom_range(0, 1) == 1) begin
                    p.b_x = CB'(sat_coord(ax - int'(p.b_w)));
                end
            end else begin
                p.b_x = CB'(sat_coord(ax + $urandom_range(0, aw + 64) - 32));
                p.b_y = CB'(sat_coord(ay + $urandom_range(0, ah + 64) - 32));
            end
        end
        return p;
    endfunction

    function automatic bit idle_allowed(int k, int total);
        return !(k >= 300 && k < 420) && (k < total - TAIL_ITEMS);
    endfunction

    // Sender.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_ratios.push_back(predict_overlap(cur_pair));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (n_offered == PAUSE_AT && expected_ratios.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_pairs.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (idle_allowed(n_offered, n_items) && $urandom_range(0, 7) == 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap <= $urandom_range(0, 9);
                end else begin
                    cur_pair = pending_pairs.pop_front();
                    s_tdata  <= IN_W'({cur_pair.b_h, cur_pair.b_w, cur_pair.b_y, cur_pair.b_x,
                                       cur_pair.a_h, cur_pair.a_w, cur_pair.a_y, cur_pair.a_x});
                    s_tuser  <= cur_pair.cmd;
                    s_tvalid <= 1'b1;
                    n_offered <= n_offered + 1;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold that backs up the pipeline.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (!long_hold_done && n_results >= HOLD_AT) begin
            long_hold_done <= 1'b1;
            hold_cnt <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if (idle_allowed(n_results + 100, n_items) && n_results < n_items - TAIL_ITEMS
                     && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_gap <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results <= n_results + 1;
            got.ratio            = m_tdata[RATIO_W-1:0];
            got.overlap_area     = m_tdata[RATIO_W +: OVL_W];
            got.denominator      = m_tdata[RATIO_W + OVL_W +: DEN_W];
            got.zero_denominator = m_tuser;
            if (expected_ratios.size() == 0) begin
                $error("result item arrived with no expectation pending");
                n_fail = n_fail + 1;
            end else begin
                want = expected_ratios.pop_front();
                if (got.ratio !== want.ratio) begin
                    $error("ratio: expected %0d, got %0d", want.ratio, got.ratio);
                    n_fail = n_fail + 1;
                end
                if (got.overlap_area !== want.overlap_area) begin
                    $error("overlap_area: expected %0d, got %0d",
                           want.overlap_area, got.overlap_area);
                    n_fail = n_fail + 1;
                end
                if (got.denominator !== want.denominator) begin
                    $error("denominator: expected %0d, got %0d",
                           want.denominator, got.denominator);
                    n_fail = n_fail + 1;
                end
                if (got.zero_denominator !== want.zero_denominator) begin
                    $error("zero_denominator: expected %0d, got %0d",
                           want.zero_denominator, got.zero_denominator);
                    n_fail = n_fail + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // Degenerate and full-range boxes.
        pending_pairs.push_back(make_pair(CMD_IOU, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(CMD_IOA, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(CMD_IOU, 4095, 4095, 4095, 4095,
                                          4095, 4095, 4095, 4095));
        pending_pairs.push_back(make_pair(CMD_IOA, 4095, 4095, 4095, 4095,
                                          4095, 4095, 4095, 4095));
        pending_pairs.push_back(make_pair(CMD_IOU, 0, 0, 4095, 4095, 0, 0, 4095, 4095));
        pending_pairs.push_back(make_pair(CMD_IOA, 0, 0, 4095, 4095, 0, 0, 4095, 4095));
        // Edges that meet, then separated by one on each side.
        pending_pairs.push_back(make_pair(CMD_IOU, 100, 100, 50, 50, 150, 100, 50, 50));
        pending_pairs.push_back(make_pair(CMD_IOA, 100, 100, 50, 50, 100, 150, 50, 50));
        pending_pairs.push_back(make_pair(CMD_IOU, 100, 100, 50, 50, 151, 100, 50, 50));
        pending_pairs.push_back(make_pair(CMD_IOU, 300, 100, 50, 50, 200, 100, 99, 50));
        pending_pairs.push_back(make_pair(CMD_IOA, 100, 100, 50, 50, 100, 151, 50, 50));
        pending_pairs.push_back(make_pair(CMD_IOA, 100, 300, 50, 50, 100, 200, 50, 99));
        // Containment and empty boxes.
        pending_pairs.push_back(make_pair(CMD_IOA, 0, 0, 1000, 1000, 10, 10, 20, 20));
        pending_pairs.push_back(make_pair(CMD_IOU, 0, 0, 1000, 1000, 10, 10, 20, 20));
        pending_pairs.push_back(make_pair(CMD_IOU, 0, 0, 1000, 1000, 10, 10, 0, 20));
        pending_pairs.push_back(make_pair(CMD_IOA, 10, 10, 0, 5, 0, 0, 100, 100));
        pending_pairs.push_back(make_pair(CMD_IOU, 10, 10, 0, 5, 0, 0, 100, 100));
        pending_pairs.push_back(make_pair(CMD_IOU, 0, 0, 3, 3, 1, 1, 3, 3));
        pending_pairs.push_back(make_pair(CMD_IOU, 4095, 4095, 4095, 4095, 4095, 4095, 1, 1));
        pending_pairs.push_back(make_pair(CMD_IOU, 0, 0, 0, 0, 4095, 4095, 4095, 4095));
        pending_pairs.push_back(make_pair(CMD_IOA, 5, 5, 10, 10, 0, 0, 4095, 4095));
        for (int i = 0; i < N_RANDOM; i++) begin
            pending_pairs.push_back(rand_pair());
        end
        n_items = pending_pairs.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_items || expected_ratios.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
